// File: hw/rtl/irpte_pkg.sv
// ----------------------------------------------------------------------------
// irpte_pkg : shared types and constants of the ir pulse train encoder
// Divider width, slot packing constants, register map and the request
// structures between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package irpte_pkg;

  // shared divider width, covers source clocks up to 26 MHz and 10^7
  localparam int DIV_W = 25;
  localparam int CNT_W = $clog2(DIV_W);

  // carrier period in tenths of a microsecond stays below 2561
  localparam int PER_W = 12;
  // raw carrier ticks per period stay below 2600
  localparam int P_W = 12;

  localparam int CAR_W = 20;
  localparam int HL_W = 7;
  localparam int WORD_W = 32;
  localparam int CNT16_W = 16;
  localparam int SLOTS_PER_WORD = 16;

  localparam logic [CAR_W-1:0] DEFAULT_CARRIER_HZ = 20'd38000;
  localparam logic [CAR_W-1:0] CARRIER_LOW_EXCL = 20'd10000;
  localparam logic [CAR_W-1:0] CARRIER_HIGH_EXCL = 20'd100000;
  localparam logic [DIV_W-1:0] TENTHS_US_PER_S = 25'd10000000;
  localparam logic [HL_W-1:0] HL_MAX = 7'd127;

  // register map: word index taken from paddr bit 2
  localparam logic REG_CARRIER_HZ = 1'b0;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic valid;
    logic [WORD_W-1:0] word;
    logic word_valid;
    logic last;
    logic [CNT16_W-1:0] count;
    logic [HL_W-1:0] high_count;
    logic [HL_W-1:0] low_count;
  } emit_t;

endpackage

`default_nettype wire

// File: hw/rtl/irpte_div.sv
// ----------------------------------------------------------------------------
// irpte_div : shared restoring divider
// Unsigned division, one quotient bit per cycle.
// Quotient and remainder hold their values until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module irpte_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  irpte_pkg::div_req_t req,
  output irpte_pkg::div_rsp_t rsp
);
  import irpte_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // one restoring step
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = ~diff[DIV_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// File: hw/rtl/irpte_seq.sv
// ----------------------------------------------------------------------------
// irpte_seq : carrier derivation and slot packing sequencer
// Drives the shared divider for the carrier timing and for each duration,
// then packs mark/space slots into 32-bit words, one word per cycle while out_free.
// ----------------------------------------------------------------------------
`default_nettype none

module irpte_seq #(
  parameter int SOURCE_CLOCK_HZ    = 1625000,
  parameter int MAX_SLOTS_PER_ITEM = 1008
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [irpte_pkg::CAR_W-1:0]       carrier_hz,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [15:0]                       in_duration_us,
  input  wire                              in_end_of_burst,
  input  wire                              out_free,
  output irpte_pkg::emit_t                 emit,
  output irpte_pkg::div_req_t              div_req,
  input  irpte_pkg::div_rsp_t              div_rsp
);
  import irpte_pkg::*;

  localparam int NW = $clog2(MAX_SLOTS_PER_ITEM + 1);
  localparam logic [DIV_W-1:0] SRC_HZ = DIV_W'(SOURCE_CLOCK_HZ);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_SLOTS_PER_ITEM);

  typedef enum logic [6:0] {
    ST_CP   = 7'b0000001,
    ST_CF   = 7'b0000010,
    ST_CT   = 7'b0000100,
    ST_IDLE = 7'b0001000,
    ST_ND   = 7'b0010000,
    ST_FILL = 7'b0100000,
    ST_END  = 7'b1000000
  } seq_st_t;

  seq_st_t              st_r, st_nxt;
  logic                 launch_r, launch_nxt;
  logic [HL_W-1:0]      high_r, high_nxt;
  logic [HL_W-1:0]      low_r, low_nxt;
  logic [PER_W-1:0]     period_r, period_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic                 eob_r, eob_nxt;
  logic [3:0]           pos_r, pos_nxt;
  logic [WORD_W-1:0]    pend_r, pend_nxt;
  logic                 mark_r, mark_nxt;
  logic [CNT16_W-1:0]   burst_r, burst_nxt;

  logic [CAR_W-1:0]     f_eff;
  logic [P_W-1:0]       p, h0, l0, h1, l1;
  logic [HL_W-1:0]      h2, l2;
  logic [8:0]           hl_sum;
  logic [DIV_W-1:0]     q_nz;
  logic [19:0]          scaled;
  logic                 rnd;
  logic [NW-1:0]        n_val;
  logic [4:0]           room, take, fill_end;
  logic                 full;
  logic [WORD_W-1:0]    mask;
  logic [CNT16_W-1:0]   burst_inc;

  // carrier timing from the divided source clock
  assign f_eff = (carrier_hz <= CARRIER_LOW_EXCL || carrier_hz >= CARRIER_HIGH_EXCL)
                 ? DEFAULT_CARRIER_HZ : carrier_hz;
  assign p  = div_rsp.quot[P_W-1:0];
  assign h0 = p >> 1;
  assign l0 = p - h0;
  assign h1 = (h0 > P_W'(2)) ? h0 - P_W'(1) : h0;
  assign l1 = (l0 > P_W'(2)) ? l0 - P_W'(1) : l0;
  assign h2 = (h1 > P_W'(HL_MAX)) ? HL_MAX : h1[HL_W-1:0];
  assign l2 = (l1 > P_W'(HL_MAX)) ? HL_MAX : l1[HL_W-1:0];
  assign hl_sum = {2'b00, high_r} + {2'b00, low_r} + 9'd2;
  assign q_nz = (div_rsp.quot == '0) ? DIV_W'(1) : div_rsp.quot;

  // duration scaling and rounded slot count
  assign scaled = {1'b0, in_duration_us, 3'b000} + {3'b000, in_duration_us, 1'b0};
  assign rnd    = div_rsp.rem > DIV_W'(period_r >> 1);
  assign n_val  = (div_rsp.quot >= DIV_W'(MAX_N)) ? MAX_N
                                                  : div_rsp.quot[NW-1:0] + NW'(rnd);

  // slots placed this cycle
  assign room     = 5'(SLOTS_PER_WORD) - {1'b0, pos_r};
  assign take     = (n_r < NW'(room)) ? n_r[4:0] : room;
  assign fill_end = {1'b0, pos_r} + take;
  assign full     = (fill_end == 5'(SLOTS_PER_WORD));

  always_comb begin
    mask = '0;
    for (int k = 0; k < SLOTS_PER_WORD; k++) begin
      mask[2*k] = mark_r && (5'(k) >= {1'b0, pos_r}) && (5'(k) < fill_end);
    end
  end

  assign burst_inc = (burst_r == '1) ? burst_r : burst_r + CNT16_W'(1);

  // divider operand selection
  always_comb begin
    div_req.start    = launch_r || (st_r == ST_IDLE && in_valid);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (st_r)
      ST_CP: begin
        div_req.dividend = SRC_HZ;
        div_req.divisor  = DIV_W'(f_eff);
      end
      ST_CF: begin
        div_req.dividend = SRC_HZ;
        div_req.divisor  = DIV_W'(hl_sum);
      end
      ST_CT: begin
        div_req.dividend = TENTHS_US_PER_S;
        div_req.divisor  = q_nz;
      end
      ST_IDLE: begin
        div_req.dividend = DIV_W'(scaled);
        div_req.divisor  = DIV_W'(period_r);
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  assign in_ready = (st_r == ST_IDLE);

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    launch_nxt = 1'b0;
    high_nxt   = high_r;
    low_nxt    = low_r;
    period_nxt = period_r;
    n_nxt      = n_r;
    eob_nxt    = eob_r;
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    mark_nxt   = mark_r;
    burst_nxt  = burst_r;
    emit            = '0;
    emit.high_count = high_r;
    emit.low_count  = low_r;
    case (st_r)
      ST_CP: begin
        if (div_rsp.done) begin
          high_nxt   = h2;
          low_nxt    = l2;
          st_nxt     = ST_CF;
          launch_nxt = 1'b1;
        end
      end
      ST_CF: begin
        if (div_rsp.done) begin
          st_nxt     = ST_CT;
          launch_nxt = 1'b1;
        end
      end
      ST_CT: begin
        if (div_rsp.done) begin
          period_nxt = q_nz[PER_W-1:0];
          st_nxt     = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          eob_nxt = in_end_of_burst;
          st_nxt  = ST_ND;
        end
      end
      ST_ND: begin
        if (div_rsp.done) begin
          n_nxt  = n_val;
          st_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (n_r == '0) begin
          mark_nxt = ~mark_r;
          st_nxt   = eob_r ? ST_END : ST_IDLE;
        end else if (!full || out_free) begin
          n_nxt = n_r - NW'(take);
          if (full) begin
            emit.valid      = 1'b1;
            emit.word       = pend_r | mask;
            emit.word_valid = 1'b1;
            emit.count      = burst_inc;
            burst_nxt       = burst_inc;
            pend_nxt        = '0;
            pos_nxt         = '0;
          end else begin
            pend_nxt = pend_r | mask;
            pos_nxt  = fill_end[3:0];
          end
        end
      end
      ST_END: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.last  = 1'b1;
          if (pos_r != '0) begin
            emit.word       = pend_r;
            emit.word_valid = 1'b1;
            emit.count      = burst_inc;
          end else begin
            emit.count = burst_r;
          end
          pos_nxt   = '0;
          pend_nxt  = '0;
          mark_nxt  = 1'b1;
          burst_nxt = '0;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt     = ST_CP;
        launch_nxt = 1'b1;
      end
    endcase
    // new carrier value: derive the timing again
    if (cfg_we) begin
      st_nxt     = ST_CP;
      launch_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CP;
      launch_r <= 1'b1;
      n_r      <= '0;
      pos_r    <= '0;
      pend_r   <= '0;
      mark_r   <= 1'b1;
      burst_r  <= '0;
    end else begin
      st_r     <= st_nxt;
      launch_r <= launch_nxt;
      n_r      <= n_nxt;
      pos_r    <= pos_nxt;
      pend_r   <= pend_nxt;
      mark_r   <= mark_nxt;
      burst_r  <= burst_nxt;
    end
  end

  // carrier timing and request attributes
  always_ff @(posedge clk) begin
    high_r   <= high_nxt;
    low_r    <= low_nxt;
    period_r <= period_nxt;
    eob_r    <= eob_nxt;
  end

`ifndef SYNTHESIS
  // divider is only started when it is free
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a result is only produced when the output stage can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result produced into a full output stage");

  // end of burst leaves a clean slot state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid && emit.last |=> pos_r == '0 && mark_r && burst_r == '0)
    else $error("burst state not cleared after final result");

  // a full word always restarts at slot zero
  a_word_restart: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid && !emit.last |=> pos_r == '0 && pend_r == '0)
    else $error("slot state not cleared after full word");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/ir_pulse_train_encoder_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_train_encoder_unit : consumer ir mark/space to carrier bitstream
// Turns alternating mark/space durations into 2-bit carrier slots packed
// sixteen to a 32-bit word, with an apb-style carrier register.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one request per mark or space duration in microseconds, marks
//           first; in_end_of_burst closes the burst after that duration.
//   out_* : pattern words; full words carry out_last 0, the closing result
//           carries out_last 1 (out_word_valid 0 when no slots were pending).
//   cfg_* : carrier frequency at byte address 0; write only while idle.
// Timing
//   After reset and after each carrier write the carrier timing is derived
//   by three passes through the shared divider, after which in_ready rises.
//   Each request is accepted, divided into a slot count, then packed at
//   most one word per cycle while the output register is free, and closed
//   by a step that flips mark/space, plus a final result at end of burst.
// Reset and stalls
//   Synchronous active-low reset clears the burst, marks come first and the
//   carrier returns to 38 kHz. A result waits in the output register while
//   out_ready is low; packing pauses on the next full word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_train_encoder_unit #(
  parameter int SOURCE_CLOCK_HZ    = 1625000,
  parameter int MAX_SLOTS_PER_ITEM = 1008
) (
  input  wire         clk,
  input  wire         rst_n,
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // duration requests
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] in_duration_us,
  input  wire         in_end_of_burst,
  // pattern results
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_pattern_word,
  output logic        out_word_valid,
  output logic        out_last,
  output logic [15:0] out_word_count,
  output logic [6:0]  out_high_count,
  output logic [6:0]  out_low_count
);
  import irpte_pkg::*;

  logic [CAR_W-1:0] carrier_r, carrier_nxt;
  logic             cfg_we;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  emit_t            emit;
  emit_t            res_r;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // register write decode, byte offset bits ignored
  assign cfg_pready  = 1'b1;
  assign cfg_we      = cfg_psel && cfg_penable && cfg_pwrite &&
                       (cfg_paddr[2] == REG_CARRIER_HZ);
  assign carrier_nxt = cfg_we ? cfg_pwdata[CAR_W-1:0] : carrier_r;
  assign cfg_prdata  = (cfg_paddr[2] == REG_CARRIER_HZ) ? {12'd0, carrier_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= DEFAULT_CARRIER_HZ;
    end else begin
      carrier_r <= carrier_nxt;
    end
  end

  irpte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  irpte_seq #(
    .SOURCE_CLOCK_HZ    (SOURCE_CLOCK_HZ),
    .MAX_SLOTS_PER_ITEM (MAX_SLOTS_PER_ITEM)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .carrier_hz      (carrier_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_duration_us  (in_duration_us),
    .in_end_of_burst (in_end_of_burst),
    .out_free        (out_free),
    .emit            (emit),
    .div_req         (div_req),
    .div_rsp         (div_rsp)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      res_r <= emit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pattern_word = res_r.word;
  assign out_word_valid   = res_r.word_valid;
  assign out_last         = res_r.last;
  assign out_word_count   = res_r.count;
  assign out_high_count   = res_r.high_count;
  assign out_low_count    = res_r.low_count;

`ifndef SYNTHESIS
  // a carrier write restarts the timing derivation, so no request is taken
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("request taken during carrier derivation");

  // a waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_r))
    else $error("stalled result changed");

  // an empty marker is always the final result of a burst and carries no slots
  a_marker_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word_valid |-> out_last && out_pattern_word == 32'd0)
    else $error("empty marker not flagged as final");
`endif

endmodule

`default_nettype wire
